### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the dew point unit.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an implication holds on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checks that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

### rtl/core/dpp_pkg.sv
// Types, constants and the log2 table function of the dew point unit.
// Used by every module of the unit except dpp_div; depends on nothing.
package dpp_pkg;

  // Input sample.
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [16:0]        pressure_pa;
  } dpp_in_t;

  // Result.
  typedef struct packed {
    logic signed [15:0] dew_point_centi;
    logic               dew_point_valid;
    logic               temperature_ok;
    logic               humidity_ok;
    logic               pressure_ok;
    logic               all_plausible;
  } dpp_out_t;

  // Classification of one item, decided at the front.
  typedef struct packed {
    logic valid;
    logic t_ok;
    logic h_ok;
    logic p_ok;
    logic all_ok;
  } dpp_flags_t;

  // Entry of the queue between front and back.
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    dpp_flags_t         flags;
  } dpp_item_t;

  // Side data carried through the first divider.
  typedef struct packed {
    logic signed [20:0] ln;
    logic               neg;
    dpp_flags_t         flags;
  } dpp_tag1_t;

  // Side data carried through the second divider.
  typedef struct packed {
    logic       bad;
    logic       aneg;
    dpp_flags_t flags;
  } dpp_tag2_t;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Range checks.
  localparam logic signed [14:0] T_MIN = -15'sd4000;
  localparam logic signed [14:0] T_MAX = 15'sd8500;
  localparam logic [13:0] H_MAX = 14'd10000;
  localparam logic [16:0] P_MIN = 17'd30000;
  localparam logic [16:0] P_MAX = 17'd110000;

  // Magnus constants in fixed point.
  localparam logic [25:0] MAG_A = 26'd1727;
  localparam logic [16:0] MAG_B_CENTI = 17'd23770;
  localparam logic [21:0] CENTI_SCALE = 22'd100;
  localparam logic [51:0] LN2_Q32 = 52'd2977044472;
  localparam logic signed [20:0] LN_10000_Q16 = 21'sd603610;
  localparam logic signed [31:0] DEN_OFS = 32'sd113180672;
  localparam logic [44:0] NUM_SCALE = 45'd2377000;
  localparam logic signed [16:0] DEW_LOW = -17'sd23770;
  localparam logic signed [16:0] DEW_HIGH = 17'sd15000;

  // log2(1 + i/2^bits) in Q16, by truncating squaring steps in Q30.
  function automatic logic [16:0] log2_point(input int unsigned i, input int unsigned bits);
    logic [63:0] y;
    logic [16:0] r;
    r = '0;
    if (i >= (32'd1 << bits)) begin
      return 17'd65536;
    end
    y = (64'd1 << 30) + (64'(i) << (30 - bits));
    for (int k = 15; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r = r | (17'd1 << k);
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/dpp_front.sv
// Front of the dew point unit: accepts samples, runs the range checks and
// holds classified items in a short queue. Depends on dpp_pkg.
module dpp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  dpp_pkg::dpp_in_t    sample_i,
  input  logic                deq_i,
  output logic                q_valid_o,
  output dpp_pkg::dpp_item_t  q_item_o
);

  dpp_pkg::dpp_item_t                 item_d;
  dpp_pkg::dpp_item_t                 mem_q [dpp_pkg::QUEUE_DEPTH];
  logic [dpp_pkg::QPTR_W-1:0]         wr_ptr_q;
  logic [dpp_pkg::QPTR_W-1:0]         rd_ptr_q;
  logic [dpp_pkg::QCNT_W-1:0]         cnt_q;
  logic                               push_ok;

  // Classify the sample with the datasheet range checks.
  always_comb begin
    item_d.temperature_centi = sample_i.temperature_centi;
    item_d.humidity_centi    = sample_i.humidity_centi;
    item_d.flags.valid = (sample_i.humidity_centi != '0);
    item_d.flags.t_ok  = (sample_i.temperature_centi >= dpp_pkg::T_MIN) &&
                         (sample_i.temperature_centi <= dpp_pkg::T_MAX);
    item_d.flags.h_ok  = (sample_i.humidity_centi <= dpp_pkg::H_MAX);
    item_d.flags.p_ok  = (sample_i.pressure_pa >= dpp_pkg::P_MIN) &&
                         (sample_i.pressure_pa <= dpp_pkg::P_MAX);
    item_d.flags.all_ok = item_d.flags.t_ok && item_d.flags.h_ok && item_d.flags.p_ok;
  end

  assign full      = (cnt_q == dpp_pkg::QCNT_W'(dpp_pkg::QUEUE_DEPTH));
  assign push_ok   = push && !full;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + dpp_pkg::QPTR_W'(1);
      end
      if (deq_i) begin
        rd_ptr_q <= rd_ptr_q + dpp_pkg::QPTR_W'(1);
      end
      if (push_ok && !deq_i) begin
        cnt_q <= cnt_q + dpp_pkg::QCNT_W'(1);
      end else if (!push_ok && deq_i) begin
        cnt_q <= cnt_q - dpp_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/dpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Used by the back of the dew point unit; depends on nothing.
module dpp_div #(
  parameter int NW = 42,
  parameter int DW = 23,
  parameter int QW = 22,
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  logic [NW-1:0] in_num_i,
  input  logic [DW-1:0] in_den_i,
  input  logic [TW-1:0] in_tag_i,
  output logic          out_valid_o,
  output logic [QW-1:0] out_quo_o,
  output logic [TW-1:0] out_tag_o
);

  localparam int WW = NW + DW;

  logic          vld_q [QW];
  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [TW-1:0] tag_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam logic [QW-1:0] QBIT = QW'(1) << (QW - 1 - s);
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [WW-1:0] dsh;
    logic [WW-1:0] diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign rem_in = in_num_i;
      assign den_in = in_den_i;
      assign quo_in = '0;
      assign tag_in = in_tag_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    // Try to take the shifted divisor out of the partial remainder.
    assign dsh  = WW'(den_in) << (QW - 1 - s);
    assign ge   = ({{DW{1'b0}}, rem_in} >= dsh);
    assign diff = {{DW{1'b0}}, rem_in} - dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[NW-1:0] : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= ge ? (quo_in | QBIT) : quo_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign out_valid_o = vld_q[QW-1];
  assign out_quo_o   = quo_q[QW-1];
  assign out_tag_o   = tag_q[QW-1];

endmodule

### rtl/core/dpp_back.sv
// Back of the dew point unit: log2 table path, Magnus divisions, rounding,
// saturation and the result register. Depends on dpp_pkg and dpp_div.
module dpp_back #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dpp_pkg::dpp_item_t q_item_i,
  output logic               deq_o,
  input  logic               pop,
  output logic               empty,
  output dpp_pkg::dpp_out_t  result_o
);

  localparam int TBL_N = 1 << LOG_TABLE_BITS;
  localparam int RW    = 16 - LOG_TABLE_BITS;
  localparam int PW    = 17 + RW;
  localparam logic [PW-1:0] HALF = PW'(1) << (RW - 1);
  localparam int TAG1_W = $bits(dpp_pkg::dpp_tag1_t);
  localparam int TAG2_W = $bits(dpp_pkg::dpp_tag2_t);

  logic en;

  // Constant log2 table.
  logic [16:0] tbl [TBL_N + 1];
  for (genvar gi = 0; gi <= TBL_N; gi++) begin : g_tbl
    localparam logic [16:0] PT = dpp_pkg::log2_point(gi, LOG_TABLE_BITS);
    assign tbl[gi] = PT;
  end

  // The whole back advances unless a result waits and is not taken.
  logic out_vld_q;
  assign en    = !out_vld_q || pop;
  assign deq_o = en && q_valid_i;
  assign empty = !out_vld_q;

  // Stage A: temperature terms and log2 normalization.
  logic                   vld_a_q;
  dpp_pkg::dpp_flags_t    flags_a_q;
  logic                   neg_a_q;
  logic [25:0]            prod1_a_q;
  logic [21:0]            d1_a_q;
  logic [3:0]             e_a_q;
  logic [LOG_TABLE_BITS-1:0] idx_a_q;
  logic [RW-1:0]          rem_a_q;

  logic [14:0] tmag;
  logic [16:0] tsum;
  logic [3:0]  e_d;
  logic [29:0] nsh;

  assign tmag = q_item_i.temperature_centi[14] ? 15'(-q_item_i.temperature_centi)
                                               : 15'(q_item_i.temperature_centi);
  assign tsum = {{2{q_item_i.temperature_centi[14]}}, q_item_i.temperature_centi} +
                dpp_pkg::MAG_B_CENTI;

  // Index of the leading one of the humidity.
  always_comb begin
    e_d = '0;
    for (int i = 1; i < 14; i++) begin
      if (q_item_i.humidity_centi[i]) begin
        e_d = 4'(i);
      end
    end
  end

  assign nsh = 30'(q_item_i.humidity_centi) << (5'd16 - 5'(e_d));

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_a_q <= q_item_i.flags;
      neg_a_q   <= q_item_i.temperature_centi[14];
      prod1_a_q <= 26'(tmag) * dpp_pkg::MAG_A;
      d1_a_q    <= 22'(tsum[15:0]) * dpp_pkg::CENTI_SCALE;
      e_a_q     <= e_d;
      idx_a_q   <= nsh[15 -: LOG_TABLE_BITS];
      rem_a_q   <= nsh[RW-1:0];
    end
  end

  // Stage B: table lookup and dividend forming.
  logic                vld_b_q;
  dpp_pkg::dpp_flags_t flags_b_q;
  logic                neg_b_q;
  logic [41:0]         num1_b_q;
  logic [22:0]         den1_b_q;
  logic [3:0]          e_b_q;
  logic [RW-1:0]       rem_b_q;
  logic [16:0]         lo_b_q;
  logic [16:0]         diff_b_q;
  logic [LOG_TABLE_BITS:0] idx_lo;
  logic [LOG_TABLE_BITS:0] idx_hi;

  assign idx_lo = {1'b0, idx_a_q};
  assign idx_hi = idx_lo + (LOG_TABLE_BITS + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_b_q <= flags_a_q;
      neg_b_q   <= neg_a_q;
      num1_b_q  <= {prod1_a_q[24:0], 17'd0} + 42'(d1_a_q);
      den1_b_q  <= {d1_a_q, 1'b0};
      e_b_q     <= e_a_q;
      rem_b_q   <= rem_a_q;
      lo_b_q    <= tbl[idx_lo];
      diff_b_q  <= tbl[idx_hi] - tbl[idx_lo];
    end
  end

  // Stage C: interpolated log2 in Q16.
  logic                vld_c_q;
  dpp_pkg::dpp_flags_t flags_c_q;
  logic                neg_c_q;
  logic [41:0]         num1_c_q;
  logic [22:0]         den1_c_q;
  logic [19:0]         l2_c_q;
  logic [PW-1:0]       interp;

  assign interp = (PW'(diff_b_q) * PW'(rem_b_q) + HALF) >> RW;

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_c_q <= flags_b_q;
      neg_c_q   <= neg_b_q;
      num1_c_q  <= num1_b_q;
      den1_c_q  <= den1_b_q;
      l2_c_q    <= {e_b_q, 16'd0} + 20'(lo_b_q) + 20'(interp);
    end
  end

  // Stage D: scale log2 by ln 2.
  logic                vld_d_q;
  dpp_pkg::dpp_flags_t flags_d_q;
  logic                neg_d_q;
  logic [41:0]         num1_d_q;
  logic [22:0]         den1_d_q;
  logic [51:0]         lnp_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_d_q <= flags_c_q;
      neg_d_q   <= neg_c_q;
      num1_d_q  <= num1_c_q;
      den1_d_q  <= den1_c_q;
      lnp_d_q   <= 52'(l2_c_q) * dpp_pkg::LN2_Q32;
    end
  end

  // Stage E: round and move to ln(RH/100).
  logic                vld_e_q;
  logic [41:0]         num1_e_q;
  logic [22:0]         den1_e_q;
  dpp_pkg::dpp_tag1_t  tag1_e_q;
  logic [51:0]         lnr;

  assign lnr = lnp_d_q + (52'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_e_q       <= num1_d_q;
      den1_e_q       <= den1_d_q;
      tag1_e_q.ln    <= $signed({1'b0, lnr[51:32]}) - dpp_pkg::LN_10000_Q16;
      tag1_e_q.neg   <= neg_d_q;
      tag1_e_q.flags <= flags_d_q;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= q_valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
    end
  end

  // First division: a*T/(b+T) rounded.
  logic               vld_1;
  logic [21:0]        q1;
  logic [TAG1_W-1:0]  tag1_raw;
  dpp_pkg::dpp_tag1_t tag1;

  dpp_div #(.NW(42), .DW(23), .QW(22), .TW(TAG1_W)) u_div1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (vld_e_q),
    .in_num_i    (num1_e_q),
    .in_den_i    (den1_e_q),
    .in_tag_i    (tag1_e_q),
    .out_valid_o (vld_1),
    .out_quo_o   (q1),
    .out_tag_o   (tag1_raw)
  );
  assign tag1 = tag1_raw;

  // Stage F: alpha = term1 + ln.
  logic                vld_f_q;
  dpp_pkg::dpp_flags_t flags_f_q;
  logic signed [23:0]  alpha_f_q;
  logic signed [23:0]  term1;

  assign term1 = tag1.neg ? -$signed({2'b00, q1}) : $signed({2'b00, q1});

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_f_q <= tag1.flags;
      alpha_f_q <= term1 + 24'(tag1.ln);
    end
  end

  // Stage G: numerator product and divisor of the second division.
  logic                vld_g_q;
  dpp_pkg::dpp_flags_t flags_g_q;
  logic                aneg_g_q;
  logic [44:0]         nprod_g_q;
  logic signed [31:0]  den_g_q;
  logic [22:0]         amag;

  assign amag = alpha_f_q[23] ? 23'(-alpha_f_q) : 23'(alpha_f_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_g_q <= flags_f_q;
      aneg_g_q  <= alpha_f_q[23];
      nprod_g_q <= 45'(amag) * dpp_pkg::NUM_SCALE;
      den_g_q   <= dpp_pkg::DEN_OFS - (32'(alpha_f_q) * 32'sd100);
    end
  end

  // Stage H: rounding offset and divisor check.
  logic               vld_h_q;
  logic [45:0]        num2_h_q;
  logic [30:0]        den2_h_q;
  dpp_pkg::dpp_tag2_t tag2_h_q;
  logic               bad;
  logic [29:0]        denu;

  assign bad  = den_g_q[31] || (den_g_q == '0);
  assign denu = bad ? 30'd1 : den_g_q[29:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      num2_h_q       <= {nprod_g_q, 1'b0} + 46'(denu);
      den2_h_q       <= {denu, 1'b0};
      tag2_h_q.bad   <= bad;
      tag2_h_q.aneg  <= aneg_g_q;
      tag2_h_q.flags <= flags_g_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
      vld_h_q <= 1'b0;
    end else if (en) begin
      vld_f_q <= vld_1;
      vld_g_q <= vld_f_q;
      vld_h_q <= vld_g_q;
    end
  end

  // Second division: b*alpha/(a-alpha) rounded.
  logic               vld_2;
  logic [15:0]        q2;
  logic [TAG2_W-1:0]  tag2_raw;
  dpp_pkg::dpp_tag2_t tag2;

  dpp_div #(.NW(46), .DW(31), .QW(16), .TW(TAG2_W)) u_div2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (vld_h_q),
    .in_num_i    (num2_h_q),
    .in_den_i    (den2_h_q),
    .in_tag_i    (tag2_h_q),
    .out_valid_o (vld_2),
    .out_quo_o   (q2),
    .out_tag_o   (tag2_raw)
  );
  assign tag2 = tag2_raw;

  // Stage I: sign, saturation and the result register.
  dpp_pkg::dpp_out_t  out_d;
  dpp_pkg::dpp_out_t  out_q;
  logic signed [16:0] dewv;

  assign dewv = tag2.aneg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});

  always_comb begin
    out_d.dew_point_valid = tag2.flags.valid;
    out_d.temperature_ok  = tag2.flags.t_ok;
    out_d.humidity_ok     = tag2.flags.h_ok;
    out_d.pressure_ok     = tag2.flags.p_ok;
    out_d.all_plausible   = tag2.flags.all_ok;
    if (!tag2.flags.valid) begin
      out_d.dew_point_centi = '0;
    end else if (tag2.bad || (dewv > dpp_pkg::DEW_HIGH)) begin
      out_d.dew_point_centi = 16'(dpp_pkg::DEW_HIGH);
    end else if (dewv < dpp_pkg::DEW_LOW) begin
      out_d.dew_point_centi = 16'(dpp_pkg::DEW_LOW);
    end else begin
      out_d.dew_point_centi = 16'(dewv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_2;
    end
  end

  assign result_o = out_q;

endmodule

### rtl/core/dew_point_with_plausibility_unit.sv
// Top level of the dew point unit with plausibility flags.
// Depends on dpp_pkg, dpp_front, dpp_back and assert_macros.svh.
//
// Usage: samples go in through a queue-style port (push/full) and results
// come out through another (empty/pop). A sample is taken at a clock edge
// with push high and full low; the oldest result sits on result_o while
// empty is low and is removed at an edge with pop high.
// Each sample yields exactly one result, in order. The result holds the
// Magnus dew point in hundredths of a degree, its valid bit and the
// temperature, humidity and pressure range checks.
// Throughput: one sample per cycle while each result is popped as it shows.
// Each sample passes the log2 and rounding stages and the two bit-per-stage
// dividers (22 and 16 stages).
// Reset empties the queue and all pipeline stages; no result is shown.
// When a result waits and pop stays low, the back pipeline holds in place and
// the four-entry input queue keeps taking samples until full rises.
`include "assert_macros.svh"
module dew_point_with_plausibility_unit #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  dpp_pkg::dpp_in_t  sample_i,
  output logic              empty,
  input  logic              pop,
  output dpp_pkg::dpp_out_t result_o
);

  logic               q_valid;
  logic               deq;
  dpp_pkg::dpp_item_t q_item;

  // Front: classification and queue.
  dpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .sample_i  (sample_i),
    .deq_i     (deq),
    .q_valid_o (q_valid),
    .q_item_o  (q_item)
  );

  // Back: arithmetic pipeline and result register.
  dpp_back #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .deq_o     (deq),
    .pop       (pop),
    .empty     (empty),
    .result_o  (result_o)
  );

  // The back never takes an item from an empty queue.
  `ASSERT_NEVER(a_deq_empty, clk_i, rst_ni, deq && !q_valid)
  // A full queue stays full while the back takes nothing.
  `ASSERT_PROP(a_full_holds, clk_i, rst_ni, full && !deq && !push |=> full)
  // Taking a result lets the back draw the next queued item.
  `ASSERT_PROP(a_pop_draws, clk_i, rst_ni, !empty && pop && q_valid |-> deq)

endmodule
